[rtl/ipv4rc_pkg.sv]
// Shared constants, codes and types of the IPv4 receive classifier.
`default_nettype none
package ipv4rc_pkg;

  // Address table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = 64;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_HDR  = 1'b1;

  // Configuration register indexes.
  localparam logic [3:0] CFG_FIRST_INDEX = 4'd0;
  localparam logic [3:0] CFG_ENTRY_COUNT = 4'd1;

  // Verdict codes.
  localparam logic [2:0] VERD_UDP      = 3'd0;
  localparam logic [2:0] VERD_ICMP     = 3'd1;
  localparam logic [2:0] VERD_BAD_VER  = 3'd2;
  localparam logic [2:0] VERD_NOT_OURS = 3'd3;
  localparam logic [2:0] VERD_BAD_CSUM = 3'd4;
  localparam logic [2:0] VERD_OPTIONS  = 3'd5;
  localparam logic [2:0] VERD_FRAGMENT = 3'd6;
  localparam logic [2:0] VERD_OTHER    = 3'd7;

  // Header constants.
  localparam logic [3:0]  IPV4_VERSION = 4'd4;
  localparam logic [3:0]  MIN_HLEN     = 4'd5;
  localparam logic [4:0]  SHORT_WORDS  = 5'd10;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [15:0] CSUM_GOOD    = 16'hFFFF;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

  // Summary of a finished header, handed to the address search.
  typedef struct packed {
    logic [3:0]  version;
    logic [3:0]  hlen;
    logic        csum_ok;
    logic        frag_nz;
    logic [7:0]  proto;
    logic [31:0] dest;
  } hdr_t;

  // Classification result.
  typedef struct packed {
    logic [2:0] verdict;
    logic [3:0] slot;
    logic [7:0] proto;
  } res_t;

endpackage
`default_nettype wire

[rtl/ipv4rc_table_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ipv4rc_table_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/ipv4rc_search.sv]
// Address search sequencer and verdict selection for a finished header.
`default_nettype none
module ipv4rc_search (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire ipv4rc_pkg::hdr_t                 hdr,
  input  wire logic [3:0]                       first_index,
  input  wire logic [4:0]                       entry_count,
  output logic                                  rd_en,
  output logic [ipv4rc_pkg::TBL_AW-1:0]         rd_addr,
  input  wire logic [ipv4rc_pkg::ENTRY_W-1:0]   rd_data,
  output logic                                  res_valid,
  output ipv4rc_pkg::res_t                      res,
  input  wire logic                             res_take,
  output logic                                  idle
);
  import ipv4rc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  logic [1:0] state_r, state_nxt;
  hdr_t       hdr_r;
  logic [4:0] idx_r, idx_nxt;
  logic       pend_r, pend_nxt;
  logic [3:0] pidx_r, pidx_nxt;
  res_t       res_r, res_nxt;
  logic       issue;
  logic       hit;

  // Verdict once the destination has matched a table slot.
  function automatic logic [2:0] match_verdict(input hdr_t h);
    logic [2:0] v;
    if (!h.csum_ok) begin
      v = VERD_BAD_CSUM;
    end else if (h.hlen != MIN_HLEN) begin
      v = VERD_OPTIONS;
    end else if (h.frag_nz) begin
      v = VERD_FRAGMENT;
    end else if (h.proto == PROTO_UDP) begin
      v = VERD_UDP;
    end else if (h.proto == PROTO_ICMP) begin
      v = VERD_ICMP;
    end else begin
      v = VERD_OTHER;
    end
    return v;
  endfunction

  // A slot is read while it lies inside the configured range.
  assign issue   = (idx_r < entry_count) && (idx_r < 5'(TABLE_DEPTH));
  assign rd_en   = (state_r == ST_SEARCH) && issue;
  assign rd_addr = idx_r[TBL_AW-1:0];

  // Compare the returned entry against the destination.
  assign hit = pend_r && ((hdr_r.dest == rd_data[ENTRY_W-1:32]) ||
                          (hdr_r.dest == rd_data[31:0]));

  assign res_valid = (state_r == ST_HOLD);
  assign res       = res_r;
  assign idle      = (state_r == ST_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_nxt.proto = hdr_r.proto;
        res_nxt.slot  = '0;
        idx_nxt       = {1'b0, first_index};
        pend_nxt      = 1'b0;
        if (hdr_r.version != IPV4_VERSION) begin
          res_nxt.verdict = VERD_BAD_VER;
          state_nxt       = ST_HOLD;
        end else if (({1'b0, first_index} >= entry_count) ||
                     ({1'b0, first_index} >= 5'(TABLE_DEPTH))) begin
          res_nxt.verdict = VERD_NOT_OURS;
          state_nxt       = ST_HOLD;
        end else if (hdr_r.dest == ALL_ONES) begin
          // All-ones is broadcast on the first slot searched.
          res_nxt.verdict = match_verdict(hdr_r);
          res_nxt.slot    = first_index;
          state_nxt       = ST_HOLD;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          res_nxt.verdict = match_verdict(hdr_r);
          res_nxt.slot    = pidx_r;
          state_nxt       = ST_HOLD;
        end else if (!issue) begin
          res_nxt.verdict = VERD_NOT_OURS;
          res_nxt.slot    = '0;
          state_nxt       = ST_HOLD;
        end else begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[3:0];
          idx_nxt  = idx_r + 5'd1;
        end
      end
      ST_HOLD: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    if (start && (state_r == ST_IDLE)) begin
      hdr_r <= hdr;
    end
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    res_r  <= res_nxt;
  end

  // A started header is picked up in the following cycle.
  a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (start && idle) |=> (state_r == ST_CHECK))
    else $error("started header not taken into the check state");

  // Reads never leave the configured search range.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> ((rd_addr >= first_index) && ({1'b0, rd_addr} < entry_count)))
    else $error("table read outside the search range");

  // A matched slot lies inside the search range.
  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.verdict != VERD_BAD_VER) && (res.verdict != VERD_NOT_OURS))
      |-> ((res.slot >= first_index) && ({1'b0, res.slot} < entry_count)))
    else $error("matched slot outside the search range");

  // Unmatched verdicts report slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && ((res.verdict == VERD_BAD_VER) || (res.verdict == VERD_NOT_OURS)))
      |-> (res.slot == 4'd0))
    else $error("nonzero slot on an unmatched verdict");

endmodule
`default_nettype wire

[rtl/ipv4_receive_classifier.sv]
// Top level of the IPv4 receive classifier: header capture, table and output register.
`default_nettype none
// The block accepts one beat per cycle: either a load of one address table
// slot (interface and broadcast address, kept in a 16 x 64-bit synchronous
// RAM) or one 16-bit header word. Header words stream in at one per cycle
// while the checksum and header fields are gathered in registers. The beat
// that completes a header starts the address search and input is held off
// until the verdict has moved into the output register: a check state,
// then, unless the check decides it, a search state that reads the table
// slots in turn, and a hold state until the output register takes the
// verdict. Input is held off longer while the output register still holds
// an earlier verdict that has not been taken. Holding input off during the
// search also keeps table loads away from the RAM read. Table slots need no
// clearing after reset; a slot must be loaded before a search reaches it.
module ipv4_receive_classifier (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [15:0] in_header_word,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic [31:0] in_entry_address,
  input  wire logic [31:0] in_entry_broadcast,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_verdict,
  output logic [3:0]       out_matched_index,
  output logic [7:0]       out_protocol,
  // Configuration channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import ipv4rc_pkg::*;

  logic        in_acc, hdr_acc, load_acc, last_word;
  logic        srch_idle, res_valid, res_take;
  res_t        res;
  hdr_t        hdr_sum;
  logic        rd_en;
  logic [TBL_AW-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic        ram_we;

  logic [3:0]  first_index_r;
  logic [4:0]  entry_count_r;

  logic [15:0] csum_r, csum_nxt;
  logic [16:0] csum_wide;
  logic [4:0]  wcnt_r, wcnt_nxt, target;
  logic [3:0]  ver_r, ver_nxt;
  logic [3:0]  hlen_r, hlen_nxt;
  logic [31:0] dest_r, dest_nxt;
  logic [12:0] frag_r, frag_nxt;
  logic [7:0]  proto_r, proto_nxt;

  logic        out_valid_r;
  res_t        out_r;

  // Handshakes.
  assign in_ready  = srch_idle;
  assign in_acc    = in_valid && in_ready;
  assign hdr_acc   = in_acc && (in_command == CMD_HDR);
  assign load_acc  = in_acc && (in_command == CMD_LOAD);
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_index_r <= '0;
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_INDEX: first_index_r <= cfg_data[3:0];
        CFG_ENTRY_COUNT: entry_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address table: interface address in the upper half, broadcast below.
  assign ram_we = load_acc && ({1'b0, in_entry_index} < 5'(TABLE_DEPTH));

  ipv4rc_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_entry_index[TBL_AW-1:0]),
    .wdata ({in_entry_address, in_entry_broadcast}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // One's-complement running sum with end-around carry.
  assign csum_wide = {1'b0, csum_r} + {1'b0, in_header_word};
  assign csum_nxt  = csum_wide[15:0] + {15'd0, csum_wide[16]};

  // Field capture by word position.
  always_comb begin
    ver_nxt   = ver_r;
    hlen_nxt  = hlen_r;
    frag_nxt  = frag_r;
    proto_nxt = proto_r;
    dest_nxt  = dest_r;
    case (wcnt_r)
      5'd0: begin
        ver_nxt  = in_header_word[15:12];
        hlen_nxt = in_header_word[11:8];
      end
      5'd3: frag_nxt  = in_header_word[12:0];
      5'd4: proto_nxt = in_header_word[7:0];
      5'd8: dest_nxt  = {in_header_word, dest_r[15:0]};
      5'd9: dest_nxt  = {dest_r[31:16], in_header_word};
      default: ;
    endcase
  end

  // The header ends after twice its length in words, or ten when too short.
  assign wcnt_nxt  = wcnt_r + 5'd1;
  assign target    = (hlen_nxt >= MIN_HLEN) ? {hlen_nxt, 1'b0} : SHORT_WORDS;
  assign last_word = hdr_acc && (wcnt_nxt >= target);

  assign hdr_sum.version = ver_nxt;
  assign hdr_sum.hlen    = hlen_nxt;
  assign hdr_sum.csum_ok = (csum_nxt == CSUM_GOOD);
  assign hdr_sum.frag_nz = (frag_nxt != 13'd0);
  assign hdr_sum.proto   = proto_nxt;
  assign hdr_sum.dest    = dest_nxt;

  // Per-header state, cleared once the header is handed over.
  always_ff @(posedge clk) begin
    if (!rst_n || last_word) begin
      csum_r  <= '0;
      wcnt_r  <= '0;
      ver_r   <= '0;
      hlen_r  <= '0;
      dest_r  <= '0;
      frag_r  <= '0;
      proto_r <= '0;
    end else if (hdr_acc) begin
      csum_r  <= csum_nxt;
      wcnt_r  <= wcnt_nxt;
      ver_r   <= ver_nxt;
      hlen_r  <= hlen_nxt;
      dest_r  <= dest_nxt;
      frag_r  <= frag_nxt;
      proto_r <= proto_nxt;
    end
  end

  // Address search and verdict.
  ipv4rc_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (last_word),
    .hdr         (hdr_sum),
    .first_index (first_index_r),
    .entry_count (entry_count_r),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take),
    .idle        (srch_idle)
  );

  // Output register.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_r.verdict;
  assign out_matched_index = out_r.slot;
  assign out_protocol      = out_r.proto;

  // No table write while a search may be reading the table.
  a_no_load_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !ram_we)
    else $error("table load during address search");

  // The word counter is clear whenever a search is in progress.
  a_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !srch_idle |-> (wcnt_r == 5'd0))
    else $error("header words gathered during a search");

  // A result leaving the search always lands in the output register.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (out_valid && (out_verdict == $past(res.verdict))))
    else $error("search result lost on its way to the output");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the IPv4 receive classifier: directed and random beats against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv4rc_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 1000;
  localparam int PHASE_BEATS   = 110;

  // Register index beyond the two real registers, written to check it is ignored.
  localparam logic [3:0] CFG_LAST_INDEX = 4'd15;

  // Header values used by the directed part.
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [3:0] IPV6_VERSION = 4'd6;

  // One input beat as it appears on the input channel.
  typedef struct {
    logic        cmd;
    logic [15:0] word;
    logic [3:0]  idx;
    logic [31:0] addr;
    logic [31:0] bcast;
  } in_beat_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic        in_command         = CMD_LOAD;
  logic [15:0] in_header_word     = '0;
  logic [3:0]  in_entry_index     = '0;
  logic [31:0] in_entry_address   = '0;
  logic [31:0] in_entry_broadcast = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_verdict;
  logic [3:0]  out_matched_index;
  logic [7:0]  out_protocol;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [4:0]  cfg_data  = '0;

  ipv4_receive_classifier u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_header_word     (in_header_word),
    .in_entry_index     (in_entry_index),
    .in_entry_address   (in_entry_address),
    .in_entry_broadcast (in_entry_broadcast),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .out_matched_index  (out_matched_index),
    .out_protocol       (out_protocol),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Beats waiting to be driven, and the counts used to tell when the block is idle.
  in_beat_t    beat_q[$];
  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  logic [15:0] pkt_words[$];

  // Predicted block state: address table, header being gathered and registers.
  logic [31:0] tbl_addr  [TABLE_DEPTH] = '{default: '0};
  logic [31:0] tbl_bcast [TABLE_DEPTH] = '{default: '0};
  logic [15:0] hdr_sum     = '0;
  logic [4:0]  hdr_words   = '0;
  logic [3:0]  hdr_version = '0;
  logic [3:0]  hdr_hlen    = '0;
  logic [12:0] hdr_frag    = '0;
  logic [7:0]  hdr_proto   = '0;
  logic [31:0] hdr_dest    = '0;
  logic [3:0]  cfg_first   = '0;
  logic [4:0]  cfg_count   = '0;
  res_t        verdict_q[$];

  // Table contents as the stimulus generator last wrote them, used to aim destinations.
  logic [31:0] gen_addr  [TABLE_DEPTH] = '{default: '0};
  logic [31:0] gen_bcast [TABLE_DEPTH] = '{default: '0};

  int err_count   = 0;
  int idle_cycles = 0;
  int in_gap      = 0;
  int out_stall   = 0;
  bit in_taken    = 1'b0;
  bit calm        = 1'b0;

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the predicted state by one accepted beat and queue any verdict it causes.
  function automatic void absorb_beat(input in_beat_t b);
    logic [16:0] s;
    logic [4:0]  target;
    res_t        r;
    bit          hit;
    if (b.cmd == CMD_LOAD) begin
      tbl_addr[b.idx]  = b.addr;
      tbl_bcast[b.idx] = b.bcast;
      return;
    end
    s = hdr_sum + b.word;
    hdr_sum = s[15:0] + s[16];
    case (hdr_words)
      5'd0: begin
        hdr_version = b.word[15:12];
        hdr_hlen    = b.word[11:8];
      end
      5'd3: hdr_frag = b.word[12:0];
      5'd4: hdr_proto = b.word[7:0];
      5'd8: hdr_dest[31:16] = b.word;
      5'd9: hdr_dest[15:0] = b.word;
      default: ;
    endcase
    hdr_words = hdr_words + 5'd1;
    target = (hdr_hlen >= MIN_HLEN) ? {hdr_hlen, 1'b0} : SHORT_WORDS;
    if (hdr_words < target) return;

    // Header complete: run the tests in priority order.
    r.proto = hdr_proto;
    r.slot  = '0;
    if (hdr_version != IPV4_VERSION) begin
      r.verdict = VERD_BAD_VER;
    end else begin
      hit = 1'b0;
      for (int i = cfg_first; i < cfg_count && i < TABLE_DEPTH && !hit; i++) begin
        if (hdr_dest == tbl_addr[i] || hdr_dest == tbl_bcast[i] || hdr_dest == ALL_ONES) begin
          hit    = 1'b1;
          r.slot = 4'(i);
        end
      end
      if (!hit) r.verdict = VERD_NOT_OURS;
      else if (hdr_sum != CSUM_GOOD) r.verdict = VERD_BAD_CSUM;
      else if (hdr_hlen != MIN_HLEN) r.verdict = VERD_OPTIONS;
      else if (hdr_frag != '0) r.verdict = VERD_FRAGMENT;
      else if (hdr_proto == PROTO_UDP) r.verdict = VERD_UDP;
      else if (hdr_proto == PROTO_ICMP) r.verdict = VERD_ICMP;
      else r.verdict = VERD_OTHER;
    end
    verdict_q.push_back(r);

    hdr_sum     = '0;
    hdr_words   = '0;
    hdr_version = '0;
    hdr_hlen    = '0;
    hdr_frag    = '0;
    hdr_proto   = '0;
    hdr_dest    = '0;
  endfunction

  // Monitor: check result beats, feed accepted input beats to the predictor.
  always @(posedge clk) begin : monitor
    res_t     got;
    res_t     want;
    in_beat_t b;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.verdict = out_verdict;
        got.slot    = out_matched_index;
        got.proto   = out_protocol;
        if (verdict_q.size() == 0) begin
          note_error($sformatf("unexpected result: verdict %0d slot %0d protocol %0d",
                               got.verdict, got.slot, got.proto));
        end else begin
          want = verdict_q.pop_front();
          if (got.verdict !== want.verdict || got.slot !== want.slot ||
              got.proto !== want.proto) begin
            note_error($sformatf({"verdict exp %0d got %0d, slot exp %0d got %0d, ",
                                  "protocol exp %0d got %0d"},
                                 want.verdict, got.verdict, want.slot, got.slot,
                                 want.proto, got.proto));
          end
        end
      end
      if (in_valid && in_ready) begin
        b = '{in_command, in_header_word, in_entry_index, in_entry_address, in_entry_broadcast};
        absorb_beat(b);
        beats_taken++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      in_taken = in_valid && in_ready;
    end
  end

  // Driver: present the next queued beat once the previous one has gone, with random gaps.
  always @(negedge clk) begin : driver
    in_beat_t b;
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (beat_q.size() > 0) begin
        b = beat_q.pop_front();
        in_command         <= b.cmd;
        in_header_word     <= b.word;
        in_entry_index     <= b.idx;
        in_entry_address   <= b.addr;
        in_entry_broadcast <= b.bcast;
        in_valid           <= 1'b1;
        in_gap = pick_gap();
        // Now and then switch between idling and back-to-back stretches.
        if ($urandom_range(0, 59) == 0) calm = !calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall the output at random.
  always @(negedge clk) begin : receiver
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall = pick_gap();
    end
  end

  // Watchdog: give up when nothing has been accepted for too long.
  initial begin : watchdog
    do @(negedge clk); while (idle_cycles < STALL_LIMIT);
    $display("ipv4_receive_classifier verification failed");
    $finish;
  end

  // Write one register through the configuration channel and mirror it.
  task automatic write_reg(input logic [3:0] idx, input logic [4:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FIRST_INDEX) cfg_first = val[3:0];
    else if (idx == CFG_ENTRY_COUNT) cfg_count = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued beat is taken and every verdict has arrived, then let
  // the block finish any search still running.
  task automatic wait_idle();
    do @(negedge clk); while (beats_taken != beats_queued || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void push_beat(input in_beat_t b);
    beat_q.push_back(b);
    beats_queued++;
  endfunction

  function automatic void push_load(input logic [3:0] idx, input logic [31:0] a,
                                    input logic [31:0] bc);
    gen_addr[idx]  = a;
    gen_bcast[idx] = bc;
    push_beat('{CMD_LOAD, 16'($urandom), idx, a, bc});
  endfunction

  // Load a slot with fresh addresses, now and then all-ones or a copy of another slot.
  function automatic void push_random_load(input logic [3:0] idx);
    logic [31:0] a;
    logic [31:0] bc;
    int          r;
    r  = $urandom_range(0, 99);
    a  = (r < 10) ? gen_addr[$urandom_range(0, TABLE_DEPTH - 1)] :
         (r < 15) ? ALL_ONES : 32'($urandom);
    bc = ($urandom_range(0, 99) < 15) ? ALL_ONES : 32'($urandom);
    push_load(idx, a, bc);
  endfunction

  function automatic void push_word(input logic [15:0] w);
    push_beat('{CMD_HDR, w, 4'($urandom), 32'($urandom), 32'($urandom)});
  endfunction

  // Queue the words of pkt_words, with table loads slipped in between words at random.
  function automatic void push_header(input int load_pct);
    foreach (pkt_words[i]) begin
      if ($urandom_range(0, 99) < load_pct) push_random_load(4'($urandom));
      push_word(pkt_words[i]);
    end
  endfunction

  // Build a header in pkt_words; the checksum word makes the sum good unless asked not to.
  function automatic void build_header(input logic [3:0] ver, input logic [3:0] hlen,
                                       input logic [7:0] proto, input logic [12:0] frag,
                                       input logic [31:0] dst, input bit good);
    int          n;
    logic [16:0] s;
    logic [15:0] acc;
    n = (hlen >= MIN_HLEN) ? 2 * hlen : SHORT_WORDS;
    pkt_words.delete();
    pkt_words.push_back({ver, hlen, 8'($urandom)});
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back({3'($urandom), frag});
    pkt_words.push_back({8'($urandom), proto});
    pkt_words.push_back(16'h0000);
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back(dst[31:16]);
    pkt_words.push_back(dst[15:0]);
    while (pkt_words.size() < n) pkt_words.push_back(16'($urandom));
    acc = '0;
    foreach (pkt_words[i]) begin
      s   = acc + pkt_words[i];
      acc = s[15:0] + s[16];
    end
    pkt_words[5] = ~acc;
    if (!good) pkt_words[5] = pkt_words[5] ^ 16'($urandom_range(1, 16'hFFFF));
  endfunction

  // Destination aimed mostly at the searched slots, sometimes all-ones or a stranger.
  function automatic logic [31:0] pick_dest();
    int hi;
    int slot;
    int r;
    hi = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
    slot = (cfg_first < hi) ? $urandom_range(cfg_first, hi - 1) :
                              $urandom_range(0, TABLE_DEPTH - 1);
    r = $urandom_range(0, 99);
    if (r < 40) return gen_addr[slot];
    if (r < 65) return gen_bcast[slot];
    if (r < 75) return ALL_ONES;
    return 32'($urandom);
  endfunction

  // A mostly well-formed header with random content.
  function automatic void push_random_header();
    logic [3:0]  ver;
    logic [3:0]  hlen;
    logic [7:0]  proto;
    logic [12:0] frag;
    int          r;
    ver = ($urandom_range(0, 19) == 0) ? 4'($urandom) : IPV4_VERSION;
    r = $urandom_range(0, 9);
    if (r < 8) hlen = MIN_HLEN;
    else if (r == 8) hlen = 4'($urandom_range(6, 15));
    else hlen = 4'($urandom_range(0, 4));
    r = $urandom_range(0, 99);
    proto = (r < 40) ? PROTO_UDP : (r < 70) ? PROTO_ICMP : 8'($urandom);
    frag = ($urandom_range(0, 6) == 0) ? 13'($urandom_range(1, 13'h1FFF)) : 13'd0;
    build_header(ver, hlen, proto, frag, pick_dest(), $urandom_range(0, 7) != 0);
    push_header(3);
  endfunction

  // One random phase under the given register setting.
  task automatic random_phase(input logic [3:0] first, input logic [4:0] count);
    int unsigned start;
    int          r;
    write_reg(CFG_FIRST_INDEX, {1'($urandom), first});
    write_reg(CFG_ENTRY_COUNT, count);
    if ($urandom_range(0, 1) == 1)
      write_reg(4'($urandom_range(CFG_ENTRY_COUNT + 1, CFG_LAST_INDEX)), 5'($urandom));
    start = beats_queued;
    while (beats_queued - start < PHASE_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        push_random_header();
      end else if (r < 87) begin
        // Garbage header: random first word decides its length, the rest is noise.
        build_header(4'($urandom), 4'($urandom), 8'($urandom), 13'($urandom),
                     32'($urandom), 1'b0);
        foreach (pkt_words[i]) if (i > 0) pkt_words[i] = 16'($urandom);
        push_header(3);
      end else begin
        push_random_load(4'($urandom));
      end
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: search only the four slots loaded here.
    write_reg(CFG_FIRST_INDEX, 5'd0);
    write_reg(CFG_ENTRY_COUNT, 5'd4);
    write_reg(CFG_LAST_INDEX, 5'd31);
    push_load(4'd0, 32'h0A00_0001, 32'h0A00_00FF);
    push_load(4'd1, 32'hC0A8_0101, 32'hC0A8_01FF);
    push_load(4'd2, 32'h0000_0000, 32'h7FFF_FFFF);
    push_load(4'd3, 32'hFFFF_FFFE, 32'hFFFF_FFFF);

    // Each verdict in turn, the address matched three ways and an empty match.
    build_header(IPV4_VERSION, MIN_HLEN, PROTO_UDP, 13'd0, 32'hC0A8_0101, 1'b1);
    push_header(0);
    build_header(IPV4_VERSION, MIN_HLEN, PROTO_ICMP, 13'd0, 32'h0A00_00FF, 1'b1);
    push_header(0);
    build_header(IPV4_VERSION, MIN_HLEN, PROTO_TCP, 13'd0, ALL_ONES, 1'b1);
    push_header(0);
    build_header(IPV4_VERSION, MIN_HLEN, PROTO_UDP, 13'd0, 32'h0000_0000, 1'b1);
    push_header(0);
    build_header(IPV6_VERSION, MIN_HLEN, PROTO_UDP, 13'd0, 32'hC0A8_0101, 1'b1);
    push_header(0);
    build_header(IPV4_VERSION, MIN_HLEN, PROTO_UDP, 13'd0, 32'h0808_0808, 1'b1);
    push_header(0);
    build_header(IPV4_VERSION, MIN_HLEN, PROTO_UDP, 13'd0, 32'hC0A8_0101, 1'b0);
    push_header(0);
    build_header(IPV4_VERSION, 4'd6, PROTO_UDP, 13'd0, 32'hFFFF_FFFE, 1'b1);
    push_header(0);
    build_header(IPV4_VERSION, MIN_HLEN, PROTO_UDP, 13'h1FFF, 32'hC0A8_0101, 1'b1);
    push_header(0);

    // Short header lengths end after ten words and fail the options test.
    build_header(IPV4_VERSION, 4'd0, PROTO_UDP, 13'd0, 32'hC0A8_0101, 1'b1);
    push_header(0);
    build_header(IPV4_VERSION, 4'd4, PROTO_ICMP, 13'd0, 32'h0A00_0001, 1'b1);
    push_header(0);

    // Extremes of the header word: all ones (longest header) and all zeros.
    pkt_words.delete();
    repeat (30) pkt_words.push_back(16'hFFFF);
    push_header(0);
    pkt_words.delete();
    repeat (10) pkt_words.push_back(16'h0000);
    push_header(0);

    // A table load in the middle of a header must leave the header alone.
    build_header(IPV4_VERSION, MIN_HLEN, PROTO_UDP, 13'd0, 32'hC0A8_0101, 1'b1);
    foreach (pkt_words[i]) begin
      if (i == 5) push_load(4'd1, gen_addr[1], gen_bcast[1]);
      push_word(pkt_words[i]);
    end
    wait_idle();

    // Fill the whole table so that any search range is safe from here on.
    for (int i = 0; i < TABLE_DEPTH; i++) push_random_load(4'(i));
    wait_idle();

    // Random phases over a spread of register settings, extremes included.
    random_phase(4'd0, 5'd16);
    random_phase(4'd15, 5'd16);
    random_phase(4'd0, 5'd0);
    random_phase(4'd9, 5'd4);
    random_phase(4'd3, 5'd31);
    random_phase(4'd0, 5'd1);
    random_phase(4'($urandom), 5'($urandom_range(0, 16)));

    if (err_count == 0)
      $display("ipv4_receive_classifier verification clean");
    else
      $display("ipv4_receive_classifier verification failed");
    $finish;
  end

endmodule
